// ===== hdl/wsg_pkg.sv =====
// ----------------------------------------------------------------------------
// wsg_pkg
// Shared constants, stencil tables and helpers for the stencil gradient core.
// ----------------------------------------------------------------------------
package wsg_pkg;

  localparam int FRAC_BITS_DEF = 24;
  localparam int NUM_LINKS     = 27;
  localparam int LINK_W        = 5;
  localparam int ACC_W         = 64;
  localparam int DEN_W         = 5;
  localparam int IN_TDATA_W    = 104;
  localparam int IN_TUSER_W    = 2;
  localparam int OUT_TDATA_W   = 128;
  localparam int CFG_W         = 31;
  localparam logic [CFG_W-1:0] IKAPPA_RESET = 31'd16777216;
  localparam logic [DEN_W-1:0] DEN_GRAD = 5'd18;
  localparam logic [DEN_W-1:0] DEN_LAPL = 5'd9;
  localparam logic [LINK_W-1:0] LINK_CENTRE = 5'd0;
  localparam logic [LINK_W-1:0] LINK_LAST   = 5'd26;

  typedef logic signed [1:0] cv_t;

  localparam cv_t CV_X [NUM_LINKS] = '{
    0, -1, -1, -1, -1, -1, -1, -1, -1, -1,
    0, 0, 0, 0, 0, 0, 0, 0,
    1, 1, 1, 1, 1, 1, 1, 1, 1};
  localparam cv_t CV_Y [NUM_LINKS] = '{
    0, -1, -1, -1, 0, 0, 0, 1, 1, 1,
    -1, -1, -1, 0, 0, 1, 1, 1,
    -1, -1, -1, 0, 0, 0, 1, 1, 1};
  localparam cv_t CV_Z [NUM_LINKS] = '{
    0, -1, 0, 1, -1, 0, 1, -1, 0, 1,
    -1, 0, 1, -1, 1, -1, 0, 1,
    -1, 0, 1, -1, 0, 1, -1, 0, 1};

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  // Multiply an accumulator-width value by a stencil weight of -1, 0 or 1.
  function automatic logic signed [ACC_W-1:0] cv_mul(input cv_t cv,
                                                     input logic signed [ACC_W-1:0] x);
    if (cv == 2'sd1) return x;
    if (cv == -2'sd1) return -x;
    return '0;
  endfunction

endpackage

// ===== hdl/wsg_div.sv =====
// ----------------------------------------------------------------------------
// wsg_div
// Radix-16 signed divider by a small unsigned divisor, rounding to nearest
// with ties away from zero. Four quotient bits per cycle.
// ----------------------------------------------------------------------------
module wsg_div #(
  parameter int W = wsg_pkg::ACC_W
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic signed [W-1:0]          num_i,
  input  logic [wsg_pkg::DEN_W-1:0]    den_i,
  output logic                         done_o,
  output logic signed [W-1:0]          quo_o
);
  import wsg_pkg::*;

  localparam int DIGITS = W / 4;
  localparam int CNT_W  = $clog2(DIGITS + 1);
  localparam int REM_W  = DEN_W + 4;

  logic                  busy_q;
  logic                  done_q;
  logic                  neg_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [W-1:0]          mag_q;
  logic [DEN_W-1:0]      rem_q;
  logic [DEN_W-1:0]      den_q;
  logic [REM_W-1:0]      rem_sh;
  logic [REM_W-1:0]      sub_amt;
  logic [3:0]            digit;
  logic [W-1:0]          abs_num;

  assign abs_num = num_i[W-1] ? W'(-num_i) : W'(num_i);
  assign rem_sh  = {rem_q, mag_q[W-1 -: 4]};

  // The quotient digit is the largest k for which k times the divisor still fits.
  always_comb begin
    digit   = '0;
    sub_amt = '0;
    for (int k = 1; k < 16; k++) begin
      if (rem_sh >= REM_W'(k) * REM_W'(den_q)) begin
        digit   = 4'(k);
        sub_amt = REM_W'(k) * REM_W'(den_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DIGITS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Rounding is folded in by adding half the divisor to the magnitude.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[W-1];
      mag_q <= abs_num + W'(den_i >> 1);
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= DEN_W'(rem_sh - sub_amt);
      mag_q <= {mag_q[W-5:0], digit};
    end
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? -$signed(mag_q) : $signed(mag_q);

endmodule

// ===== hdl/wetting_stencil_gradient_core.sv =====
// ----------------------------------------------------------------------------
// wetting_stencil_gradient_core
// 27-point gradient and Laplacian of one order-parameter component at one
// site, with a wetting boundary gradient at solid neighbours.
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  s_axis    in         tdata: link, value, wet_c, wet_h; tuser: is_solid, wetting_on
//  m_axis    out        tdata: grad_x, grad_y, grad_z, laplacian; tuser: centre_solid
//  cfg       in         cfg_data_i: inverse_kappa
//
// Links 0 to 25 load in one cycle each while the core is idle. After link 26 the
// core runs a check step, the fluid pass over links 1 to 26, up to 3 fluid-gradient
// divides, the wetting pass (extra steps per solid link when wetting is on, multiplier
// shared), a step that claims the result register once it is free, and 4 final divides.
// A solid centre skips to the result. A pending result stalls only the end.
// Reset is asynchronous and clears control, accumulator and result registers, not the link store.
module wetting_stencil_gradient_core #(
  parameter int FRAC_BITS = wsg_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // link[4:0], value[36:5], wet_c[68:37], wet_h[100:69], zero pad
  input  logic [wsg_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // is_solid[0], wetting_on[1]
  input  logic [wsg_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // grad_x[31:0], grad_y[63:32], grad_z[95:64], laplacian[127:96]
  output logic [wsg_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // centre_solid[0]
  output logic [0:0]                        m_axis_tuser,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [wsg_pkg::CFG_W-1:0]         cfg_data_i
);
  import wsg_pkg::*;

  // inverse_kappa resets to 1.0 in the configured fixed-point format.
  localparam logic [CFG_W-1:0] IK_ONE = CFG_W'(1) << FRAC_BITS;

  typedef enum logic [2:0] {S_IDLE, S_CHK, S_P1, S_GF, S_P2, S_DRAIN, S_FIN} state_e;

  state_e               state_q;
  logic [LINK_W-1:0]    p_q;
  logic [1:0]           ax_q;
  logic [2:0]           sub_q;
  logic                 div_run_q;
  logic                 csol_q;
  logic                 wet_q;
  logic [CFG_W-1:0]     ik_q;

  logic signed [31:0]   val_q [NUM_LINKS];
  logic                 sol_q [NUM_LINKS];
  logic signed [31:0]   c_q   [NUM_LINKS];
  logic signed [31:0]   h_q   [NUM_LINKS];
  logic signed [31:0]   phi0_q;

  logic signed [ACC_W-1:0] gsum_q [3];
  logic signed [ACC_W-1:0] gf_q   [3];
  logic [DEN_W-1:0]        cnt_q  [3];
  logic signed [ACC_W-1:0] lsum_q;
  logic signed [31:0]      phib_q;
  logic signed [31:0]      t_q;
  logic signed [63:0]      prod_q;

  logic signed [31:0]   ox_q, oy_q, oz_q, ol_q;
  logic                 osol_q;
  logic                 ovalid_q;

  logic                 in_acc;
  logic [LINK_W-1:0]    in_link;
  logic                 div_start, div_done;
  logic signed [ACC_W-1:0] div_num, div_quo;
  logic [DEN_W-1:0]     div_den;
  logic signed [31:0]   mul_a, mul_b;
  logic signed [63:0]   mul_p;
  cv_t                  cvx, cvy, cvz;
  logic signed [ACC_W-1:0] dfl, sdot, shalf, gwet;

  function automatic logic signed [63:0] rnd_frac(input logic signed [63:0] x);
    logic signed [63:0] half;
    half = 64'sd1 <<< (FRAC_BITS - 1);
    if (x >= 0) return (x + half) >>> FRAC_BITS;
    return -((-x + half) >>> FRAC_BITS);
  endfunction

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_link       = s_axis_tdata[4:0];
  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;

  assign cvx = CV_X[p_q];
  assign cvy = CV_Y[p_q];
  assign cvz = CV_Z[p_q];

  assign dfl   = ACC_W'(val_q[p_q]) - ACC_W'(phi0_q);
  assign sdot  = cv_mul(cvx, gf_q[0]) + cv_mul(cvy, gf_q[1]) + cv_mul(cvz, gf_q[2]);
  assign shalf = (sdot >= 0) ? ((sdot + 1) >>> 1) : -((-sdot + 1) >>> 1);
  assign gwet  = ACC_W'(-rnd_frac(prod_q));

  // One multiplier serves both products of the wetting term.
  assign mul_a = (sub_q == 3'd1) ? c_q[p_q] : t_q;
  assign mul_b = (sub_q == 3'd1) ? phib_q : $signed({1'b0, ik_q});
  assign mul_p = mul_a * mul_b;

  always_comb begin
    div_num   = gsum_q[ax_q[1] ? 2'd2 : ax_q];
    div_den   = cnt_q[ax_q[1] ? 2'd2 : ax_q];
    div_start = 1'b0;
    if (state_q == S_GF) begin
      div_start = (ax_q != 2'd3) && (cnt_q[ax_q[1] ? 2'd2 : ax_q] != '0) && !div_run_q;
    end else if (state_q == S_FIN) begin
      div_start = !div_run_q;
      if (ax_q == 2'd3) begin
        div_num = lsum_q;
        div_den = DEN_LAPL;
      end else begin
        div_den = DEN_GRAD;
      end
    end
  end

  wsg_div #(.W(ACC_W)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_ff @(posedge clk_i) begin
    if (in_acc && (in_link < LINK_W'(NUM_LINKS))) begin
      val_q[in_link] <= s_axis_tdata[36:5];
      sol_q[in_link] <= s_axis_tuser[0];
      c_q[in_link]   <= s_axis_tdata[68:37];
      h_q[in_link]   <= s_axis_tdata[100:69];
      if (in_link == LINK_CENTRE) phi0_q <= s_axis_tdata[36:5];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      p_q       <= '0;
      ax_q      <= '0;
      sub_q     <= '0;
      div_run_q <= 1'b0;
      csol_q    <= 1'b0;
      wet_q     <= 1'b0;
      ik_q      <= IK_ONE;
      ovalid_q  <= 1'b0;
      osol_q    <= 1'b0;
      lsum_q    <= '0;
      phib_q    <= '0;
      t_q       <= '0;
      prod_q    <= '0;
      ox_q      <= '0;
      oy_q      <= '0;
      oz_q      <= '0;
      ol_q      <= '0;
      for (int a = 0; a < 3; a++) begin
        gsum_q[a] <= '0;
        gf_q[a]   <= '0;
        cnt_q[a]  <= '0;
      end
    end else begin
      if (cfg_valid_i && cfg_ready_o) ik_q <= cfg_data_i;
      if (m_axis_tvalid && m_axis_tready) ovalid_q <= 1'b0;
      if (div_start) div_run_q <= 1'b1;
      if (div_done) div_run_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_acc && in_link == LINK_CENTRE) wet_q <= s_axis_tuser[1];
          if (in_acc && in_link == LINK_LAST) state_q <= S_CHK;
        end
        S_CHK: begin
          csol_q <= sol_q[0];
          p_q    <= LINK_W'(1);
          lsum_q <= '0;
          for (int a = 0; a < 3; a++) begin
            gsum_q[a] <= '0;
            cnt_q[a]  <= '0;
          end
          state_q <= sol_q[0] ? S_DRAIN : S_P1;
        end
        S_P1: begin
          if (!sol_q[p_q]) begin
            lsum_q    <= lsum_q + dfl;
            gsum_q[0] <= gsum_q[0] + cv_mul(cvx, dfl);
            gsum_q[1] <= gsum_q[1] + cv_mul(cvy, dfl);
            gsum_q[2] <= gsum_q[2] + cv_mul(cvz, dfl);
            cnt_q[0]  <= cnt_q[0] + DEN_W'(cvx != 0);
            cnt_q[1]  <= cnt_q[1] + DEN_W'(cvy != 0);
            cnt_q[2]  <= cnt_q[2] + DEN_W'(cvz != 0);
          end
          if (p_q == LINK_LAST) begin
            ax_q    <= '0;
            state_q <= S_GF;
          end else begin
            p_q <= p_q + 1'b1;
          end
        end
        S_GF: begin
          if (ax_q == 2'd3) begin
            p_q     <= LINK_W'(1);
            sub_q   <= '0;
            state_q <= S_P2;
          end else if (cnt_q[ax_q[1] ? 2'd2 : ax_q] == '0) begin
            gf_q[ax_q[1] ? 2'd2 : ax_q] <= '0;
            ax_q <= ax_q + 1'b1;
          end else if (div_done) begin
            gf_q[ax_q[1] ? 2'd2 : ax_q] <= div_quo;
            ax_q <= ax_q + 1'b1;
          end
        end
        S_P2: begin
          if (!(sol_q[p_q] && wet_q) || sub_q == 3'd4) begin
            if (sol_q[p_q] && wet_q) begin
              lsum_q    <= lsum_q + gwet;
              gsum_q[0] <= gsum_q[0] + cv_mul(cvx, gwet);
              gsum_q[1] <= gsum_q[1] + cv_mul(cvy, gwet);
              gsum_q[2] <= gsum_q[2] + cv_mul(cvz, gwet);
            end
            sub_q <= '0;
            if (p_q == LINK_LAST) state_q <= S_DRAIN;
            else p_q <= p_q + 1'b1;
          end else begin
            case (sub_q)
              3'd0:    phib_q <= sat32(64'(phi0_q) + 64'(shalf));
              3'd2:    t_q    <= sat32(rnd_frac(prod_q) + 64'(h_q[p_q]));
              default: prod_q <= mul_p;
            endcase
            sub_q <= sub_q + 1'b1;
          end
        end
        S_DRAIN: begin
          // The result register is claimed only once the previous result has left.
          if (!ovalid_q) begin
            if (csol_q) begin
              ox_q     <= '0;
              oy_q     <= '0;
              oz_q     <= '0;
              ol_q     <= '0;
              osol_q   <= 1'b1;
              ovalid_q <= 1'b1;
              state_q  <= S_IDLE;
            end else begin
              ax_q    <= '0;
              state_q <= S_FIN;
            end
          end
        end
        S_FIN: begin
          if (div_done) begin
            case (ax_q)
              2'd0:    ox_q <= sat32(64'(div_quo));
              2'd1:    oy_q <= sat32(64'(div_quo));
              2'd2:    oz_q <= sat32(64'(div_quo));
              default: ol_q <= sat32(64'(div_quo));
            endcase
            ax_q <= ax_q + 1'b1;
            if (ax_q == 2'd3) begin
              osol_q   <= 1'b0;
              ovalid_q <= 1'b1;
              state_q  <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {ol_q, oz_q, oy_q, ox_q};
  assign m_axis_tuser  = osol_q;

  a_div_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> div_run_q) else $error("divider finished without a request");
  a_busy_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_link == LINK_LAST) |=> !s_axis_tready)
    else $error("core ready right after the last link");
  a_solid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
    else $error("solid centre result carries data");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("pending result dropped");

endmodule

// ===== dv/tb_wetting_stencil_gradient_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_wetting_stencil_gradient_core
// Streams whole 27-link sites, with noise items and aborted sites mixed in,
// through the stencil gradient core under random idling on both streams.
// A scoreboard predicts gradient, Laplacian and the solid-centre flag per
// site and compares each result transaction field by field.
// ----------------------------------------------------------------------------
module tb_wetting_stencil_gradient_core;
  import wsg_pkg::*;

  localparam int MAX_CYC = 600;

  typedef struct {
    logic [4:0]         link;
    logic signed [31:0] value;
    logic               solid;
    logic signed [31:0] wc;
    logic signed [31:0] wh;
    logic               won;
  } link_item_t;

  typedef struct {
    logic [31:0] gx, gy, gz, lap;
    logic        cs;
  } site_result_t;

  class gradient_scoreboard;
    longint       vals[NUM_LINKS], cs[NUM_LINKS], hs[NUM_LINKS];
    bit           sol[NUM_LINKS];
    bit           wet_latch;
    longint       ikappa;
    site_result_t pending[$];
    int           mismatches;

    function new();
      ikappa = 16777216;
      wet_latch = 0;
      mismatches = 0;
      foreach (vals[i]) begin
        vals[i] = 0; cs[i] = 0; hs[i] = 0; sol[i] = 0;
      end
    endfunction

    function longint rdiv(longint num, longint den);
      if (num >= 0) return (num + den / 2) / den;
      return -((-num + den / 2) / den);
    endfunction

    function longint sat(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function void note_input(link_item_t it);
      longint       gradt[NUM_LINKS];
      longint       gf[3], cnt[3], gsum[3];
      longint       cv[3];
      longint       lsum, phi0, one, s, phib, t;
      site_result_t r;
      one = longint'(1) << FRAC_BITS_DEF;
      if (it.link >= NUM_LINKS) return;
      vals[it.link] = it.value;
      sol[it.link]  = it.solid;
      cs[it.link]   = it.wc;
      hs[it.link]   = it.wh;
      if (it.link == LINK_CENTRE) wet_latch = it.won;
      if (it.link != LINK_LAST) return;
      r = '{default: '0};
      if (sol[0]) begin
        r.cs = 1'b1;
        pending.push_back(r);
        return;
      end
      phi0 = vals[0];
      lsum = 0;
      for (int a = 0; a < 3; a++) begin
        gf[a] = 0; cnt[a] = 0; gsum[a] = 0;
      end
      for (int p = 1; p < NUM_LINKS; p++) begin
        cv[0] = CV_X[p]; cv[1] = CV_Y[p]; cv[2] = CV_Z[p];
        gradt[p] = 0;
        if (!sol[p]) begin
          gradt[p] = vals[p] - phi0;
          for (int a = 0; a < 3; a++) begin
            gf[a] += cv[a] * gradt[p];
            cnt[a] += cv[a] * cv[a];
          end
        end
      end
      for (int a = 0; a < 3; a++) gf[a] = (cnt[a] > 0) ? rdiv(gf[a], cnt[a]) : 0;
      // Boundary gradient at solid neighbors from the extrapolated phi.
      for (int p = 1; p < NUM_LINKS; p++) begin
        cv[0] = CV_X[p]; cv[1] = CV_Y[p]; cv[2] = CV_Z[p];
        if (sol[p] && wet_latch) begin
          s = cv[0] * gf[0] + cv[1] * gf[1] + cv[2] * gf[2];
          phib = sat(phi0 + rdiv(s, 2));
          t = sat(rdiv(cs[p] * phib, one) + hs[p]);
          gradt[p] = -rdiv(t * ikappa, one);
        end
      end
      for (int p = 1; p < NUM_LINKS; p++) begin
        cv[0] = CV_X[p]; cv[1] = CV_Y[p]; cv[2] = CV_Z[p];
        lsum += gradt[p];
        for (int a = 0; a < 3; a++) gsum[a] += gradt[p] * cv[a];
      end
      r.gx  = 32'(sat(rdiv(gsum[0], 18)));
      r.gy  = 32'(sat(rdiv(gsum[1], 18)));
      r.gz  = 32'(sat(rdiv(gsum[2], 18)));
      r.lap = 32'(sat(rdiv(lsum, 9)));
      pending.push_back(r);
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] d, logic cs_flag);
      site_result_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result transaction: %h", d);
        return;
      end
      e = pending.pop_front();
      if (d[31:0] !== e.gx || d[63:32] !== e.gy || d[95:64] !== e.gz ||
          d[127:96] !== e.lap || cs_flag !== e.cs) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: exp gx=%h gy=%h gz=%h lap=%h cs=%b, got %h %h %h %h cs=%b",
                   e.gx, e.gy, e.gz, e.lap, e.cs,
                   d[31:0], d[63:32], d[95:64], d[127:96], cs_flag);
      end
    endfunction
  endclass

  logic                   clk_i, rst_ni;
  logic                   s_axis_tvalid, s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic [IN_TUSER_W-1:0]  s_axis_tuser;
  logic                   m_axis_tvalid, m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [0:0]             m_axis_tuser;
  logic                   cfg_valid_i, cfg_ready_o;
  logic [CFG_W-1:0]       cfg_data_i;

  gradient_scoreboard sb;
  bit calm;

  wetting_stencil_gradient_core dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= 27);
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tuser[0]);
  end

  function automatic logic signed [31:0] rand_q();
    case ($urandom_range(9))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return 32'sd0;
      3: return $urandom;
      default: return $signed($urandom_range(32'h0800_0000)) - 32'sh0400_0000;
    endcase
  endfunction

  task automatic send(link_item_t it);
    while (!calm && $urandom_range(99) < 27) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b0, it.wh, it.wc, it.value, it.link};
    s_axis_tuser  <= {it.won, it.solid};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(it);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (MAX_CYC) @(posedge clk_i);
  endtask

  task automatic write_kappa(logic [CFG_W-1:0] k);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= k;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.ikappa = k;
  endtask

  // One site in stencil order; solid_pct sets how many neighbors are walls.
  // Sometimes noise items are mixed in or the site is aborted midway.
  task automatic run_site(int solid_pct, bit noisy);
    link_item_t it;
    for (int l = 0; l < NUM_LINKS; l++) begin
      if (noisy && $urandom_range(99) < 6) begin
        it.link  = $urandom_range(99) < 50 ? 5'($urandom_range(31, 27))
                                            : 5'($urandom_range(25));
        it.value = rand_q(); it.wc = rand_q(); it.wh = rand_q();
        it.solid = 1'($urandom); it.won = 1'($urandom);
        send(it);
      end
      if (noisy && l > 3 && $urandom_range(99) < 2) return;
      it.link  = 5'(l);
      it.value = rand_q();
      it.wc    = rand_q();
      it.wh    = rand_q();
      it.won   = $urandom_range(99) < 70;
      it.solid = (l == 0) ? ($urandom_range(99) < 10)
                          : ($urandom_range(99) < solid_pct);
      send(it);
    end
  endtask

  initial begin
    logic [CFG_W-1:0] kset[5];
    link_item_t it;
    sb = new();
    rst_ni = 1'b0;
    calm = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: fill every entry, then solid centre, wetting off, all walls.
    write_kappa(IKAPPA_RESET);
    run_site(50, 1'b0);
    it = '{link: LINK_CENTRE, value: 32'sh0100_0000, solid: 1'b1, wc: 0, wh: 0, won: 1'b1};
    send(it);
    it.link = 5'd31; send(it);
    it.link = LINK_LAST; it.solid = 1'b0; it.value = 32'sh7FFF_FFFF; send(it);
    it.link = LINK_CENTRE; it.solid = 1'b0; it.won = 1'b0; send(it);
    it.link = LINK_LAST; send(it);
    for (int l = 0; l < NUM_LINKS; l++) begin
      it = '{link: 5'(l), value: (l == 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000,
             solid: l != 0, wc: 32'sh8000_0000, wh: 32'sh7FFF_FFFF, won: 1'b1};
      send(it);
    end
    drain();

    kset = '{31'h7FFF_FFFF, 31'd0, 31'd16777216, 31'd1 << 20, 31'($urandom)};
    foreach (kset[k]) begin
      write_kappa(kset[k]);
      calm = (k == 2);
      for (int s = 0; s < 5; s++)
        run_site((s % 4 == 3) ? 100 : 30, s % 2);
      calm = 1'b0;
      drain();
    end

    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/wsg_pkg.sv
hdl/wsg_div.sv
hdl/wetting_stencil_gradient_core.sv
dv/tb_wetting_stencil_gradient_core.sv
